// File: design/aabd_pkg.sv
// Shared types and constants for the anchor argmax and box decode block.
package aabd_pkg;

  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int LABEL_W = 10;
  localparam int INDEX_W = 16;
  localparam int LIMIT_W = 13;
  localparam int CORNER_W = 17;
  localparam int NUM_W = 19;
  localparam int PROD_W = 36;
  localparam int FRAC_SHIFT = 13;

  localparam int JOB_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam int REG_INDEX_W = 3;
  localparam logic [REG_INDEX_W-1:0] REG_PAD_X = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PAD_Y = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SCALE_RATIO = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_IMG_WIDTH = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_IMG_HEIGHT = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_SCORE_THRESHOLD = 3'd5;

  localparam logic [1:0] KIND_BOX = 2'd0;
  localparam logic [1:0] KIND_SCORE = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] pad_x;
    logic [COORD_W-1:0] pad_y;
    logic [15:0] scale_ratio;
    logic [LIMIT_W-1:0] img_width;
    logic [LIMIT_W-1:0] img_height;
    logic [SCORE_W-1:0] score_threshold;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] anchor_index;
    logic [LABEL_W-1:0] label;
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] box_w;
    logic [COORD_W-1:0] box_h;
  } job_t;

  typedef struct packed {
    logic [INDEX_W-1:0] anchor_index;
    logic [LABEL_W-1:0] label;
    logic [SCORE_W-1:0] score;
    logic [CORNER_W-1:0] left;
    logic [CORNER_W-1:0] top;
    logic [CORNER_W-1:0] right;
    logic [CORNER_W-1:0] bottom;
  } result_t;

endpackage

// File: design/aabd_fifo.sv
// Small register queue used between the front, the back and the result port.
module aabd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic do_push;
  logic do_pop;

  assign full = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign count = fill;
  assign rdata = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// File: design/aabd_front.sv
// Front end: running argmax over class scores, anchor counter and held box.
module aabd_front #(
  parameter int MAX_CLASSES = 1024,
  parameter int MAX_ANCHORS = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      kind,
  input  logic [aabd_pkg::COORD_W-1:0]    center_x,
  input  logic [aabd_pkg::COORD_W-1:0]    center_y,
  input  logic [aabd_pkg::COORD_W-1:0]    box_w,
  input  logic [aabd_pkg::COORD_W-1:0]    box_h,
  input  logic [aabd_pkg::SCORE_W-1:0]    class_score,
  input  logic                            last_score,
  input  logic [aabd_pkg::SCORE_W-1:0]    score_threshold,
  output logic                            job_push,
  output aabd_pkg::job_t                  job
);

  localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

  logic [AW-1:0] anchor_count;
  logic [CW-1:0] class_position;
  logic [aabd_pkg::SCORE_W-1:0] best_score;
  logic [CW-1:0] best_label;
  logic [aabd_pkg::COORD_W-1:0] held_center_x;
  logic [aabd_pkg::COORD_W-1:0] held_center_y;
  logic [aabd_pkg::COORD_W-1:0] held_box_w;
  logic [aabd_pkg::COORD_W-1:0] held_box_h;

  logic better;
  logic [aabd_pkg::SCORE_W-1:0] best_score_next;
  logic [CW-1:0] best_label_next;
  logic is_last;

  assign better = class_score > best_score;
  assign best_score_next = better ? class_score : best_score;
  assign best_label_next = better ? class_position : best_label;
  assign is_last = accept && (kind == aabd_pkg::KIND_SCORE) && last_score;

  assign job_push = is_last && (best_score_next > score_threshold);
  assign job.anchor_index = aabd_pkg::INDEX_W'(anchor_count);
  assign job.label = aabd_pkg::LABEL_W'(best_label_next);
  assign job.score = best_score_next;
  assign job.center_x = held_center_x;
  assign job.center_y = held_center_y;
  assign job.box_w = held_box_w;
  assign job.box_h = held_box_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_count <= '0;
      class_position <= '0;
      best_score <= '0;
      best_label <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_box_w <= '0;
      held_box_h <= '0;
    end else if (accept) begin
      case (kind)
        aabd_pkg::KIND_FRAME: begin
          anchor_count <= '0;
          class_position <= '0;
          best_score <= '0;
          best_label <= '0;
        end
        aabd_pkg::KIND_BOX: begin
          held_center_x <= center_x;
          held_center_y <= center_y;
          held_box_w <= box_w;
          held_box_h <= box_h;
          class_position <= '0;
          best_score <= '0;
          best_label <= '0;
        end
        aabd_pkg::KIND_SCORE: begin
          if (last_score) begin
            anchor_count <= (anchor_count == AW'(MAX_ANCHORS-1)) ? '0 : anchor_count + AW'(1);
            class_position <= '0;
            best_score <= '0;
            best_label <= '0;
          end else begin
            best_score <= best_score_next;
            best_label <= best_label_next;
            if (class_position < CW'(MAX_CLASSES-1)) begin
              class_position <= class_position + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/aabd_back.sv
// Back end: letterbox removal, scaling and clamping of the kept boxes.
module aabd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  aabd_pkg::cfg_t                      cfg,
  input  logic                                job_empty,
  input  aabd_pkg::job_t                      job,
  output logic                                job_pop,
  input  logic [$clog2(aabd_pkg::OUT_DEPTH+1)-1:0] out_count,
  output logic                                res_push,
  output aabd_pkg::result_t                   res
);

  localparam int OCW = $clog2(aabd_pkg::OUT_DEPTH+1) + 1;

  typedef struct packed {
    logic [aabd_pkg::INDEX_W-1:0] anchor_index;
    logic [aabd_pkg::LABEL_W-1:0] label;
    logic [aabd_pkg::SCORE_W-1:0] score;
  } meta_t;

  logic v1;
  logic v2;
  meta_t meta1;
  meta_t meta2;
  logic signed [aabd_pkg::NUM_W-1:0] lo_x1, hi_x1, lo_y1, hi_y1;
  logic signed [aabd_pkg::PROD_W-1:0] lo_x2, hi_x2, lo_y2, hi_y2;
  logic signed [aabd_pkg::NUM_W-1:0] ax2, ay2, wx, hy;
  logic signed [16:0] ratio_s;
  logic [OCW-1:0] in_flight;

  // Two doubled offsets per axis: 2*(centre - pad) minus and plus the size.
  assign ax2 = $signed({2'b00, job.center_x, 1'b0}) - $signed({2'b00, cfg.pad_x, 1'b0});
  assign ay2 = $signed({2'b00, job.center_y, 1'b0}) - $signed({2'b00, cfg.pad_y, 1'b0});
  assign wx = $signed({3'b000, job.box_w});
  assign hy = $signed({3'b000, job.box_h});
  assign ratio_s = $signed({1'b0, cfg.scale_ratio});

  // Results in the pipeline plus those already queued must fit in the output queue.
  assign in_flight = OCW'(out_count) + OCW'(v1) + OCW'(v2);
  assign job_pop = !job_empty && (in_flight < OCW'(aabd_pkg::OUT_DEPTH));

  function automatic logic [aabd_pkg::CORNER_W-1:0] clamp_corner(
    input logic signed [aabd_pkg::PROD_W-1:0] prod,
    input logic [aabd_pkg::LIMIT_W-1:0] limit
  );
    logic [aabd_pkg::PROD_W-aabd_pkg::FRAC_SHIFT-2:0] v;
    logic [aabd_pkg::CORNER_W-1:0] lim;
    v = prod[aabd_pkg::PROD_W-2:aabd_pkg::FRAC_SHIFT];
    lim = {limit, 4'b0000};
    if (prod[aabd_pkg::PROD_W-1] || (prod == '0)) begin
      clamp_corner = '0;
    end else if (v > (aabd_pkg::PROD_W-aabd_pkg::FRAC_SHIFT-1)'(lim)) begin
      clamp_corner = lim;
    end else begin
      clamp_corner = v[aabd_pkg::CORNER_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= job_pop;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      meta1.anchor_index <= job.anchor_index;
      meta1.label <= job.label;
      meta1.score <= job.score;
      lo_x1 <= ax2 - wx;
      hi_x1 <= ax2 + wx;
      lo_y1 <= ay2 - hy;
      hi_y1 <= ay2 + hy;
    end
    if (v1) begin
      meta2 <= meta1;
      lo_x2 <= lo_x1 * ratio_s;
      hi_x2 <= hi_x1 * ratio_s;
      lo_y2 <= lo_y1 * ratio_s;
      hi_y2 <= hi_y1 * ratio_s;
    end
  end

  assign res_push = v2;
  assign res.anchor_index = meta2.anchor_index;
  assign res.label = meta2.label;
  assign res.score = meta2.score;
  assign res.left = clamp_corner(lo_x2, cfg.img_width);
  assign res.top = clamp_corner(lo_y2, cfg.img_height);
  assign res.right = clamp_corner(hi_x2, cfg.img_width);
  assign res.bottom = clamp_corner(hi_y2, cfg.img_height);

endmodule

// File: design/anchor_argmax_box_decode_core.sv
// Top level of the anchor argmax and box decode block.
//
// Input channel: drive an item on kind and its fields with push high; it is
// taken at a rising edge where full is low. Box items latch a box, class-score
// items run the argmax, frame-start items clear the anchor counter.
// Result channel: while empty is low the oldest kept anchor sits on the result
// ports; pop high at a rising edge takes that transaction.
// Configuration: cfg_write with cfg_index and cfg_data writes one register in
// the same edge; write only while no transaction is in flight.
// Throughput is one input item per cycle while full is low. The final score
// of a kept anchor passes through the job queue, the offset registers and
// the multiplier registers, and the clamp feeds the result queue. When the
// receiver stalls the result queue fills, the back end stops draining the
// job queue, and full rises once that queue is full.
// Synchronous reset empties both queues, clears the counters and the argmax,
// and loads the registers with their defaults.
module anchor_argmax_box_decode_core #(
  parameter int MAX_CLASSES = 1024,
  parameter int MAX_ANCHORS = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [aabd_pkg::REG_INDEX_W-1:0]      cfg_index,
  input  logic [15:0]                           cfg_data,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            kind,
  input  logic [aabd_pkg::COORD_W-1:0]          center_x,
  input  logic [aabd_pkg::COORD_W-1:0]          center_y,
  input  logic [aabd_pkg::COORD_W-1:0]          box_w,
  input  logic [aabd_pkg::COORD_W-1:0]          box_h,
  input  logic [aabd_pkg::SCORE_W-1:0]          class_score,
  input  logic                                  last_score,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [aabd_pkg::INDEX_W-1:0]          anchor_index,
  output logic [aabd_pkg::LABEL_W-1:0]          label,
  output logic [aabd_pkg::SCORE_W-1:0]          score,
  output logic [aabd_pkg::CORNER_W-1:0]         left,
  output logic [aabd_pkg::CORNER_W-1:0]         top,
  output logic [aabd_pkg::CORNER_W-1:0]         right,
  output logic [aabd_pkg::CORNER_W-1:0]         bottom
);

  localparam int JOB_W = $bits(aabd_pkg::job_t);
  localparam int RES_W = $bits(aabd_pkg::result_t);
  localparam int JCW = $clog2(aabd_pkg::JOB_DEPTH+1);
  localparam int OCW = $clog2(aabd_pkg::OUT_DEPTH+1);

  aabd_pkg::cfg_t cfg;
  aabd_pkg::job_t job_in;
  aabd_pkg::job_t job_out;
  aabd_pkg::result_t res_in;
  aabd_pkg::result_t res_out;
  logic accept;
  logic job_push;
  logic job_pop;
  logic job_empty;
  logic [JCW-1:0] job_count;
  logic res_push;
  logic res_full;
  logic [OCW-1:0] res_count;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pad_x <= '0;
      cfg.pad_y <= '0;
      cfg.scale_ratio <= 16'd4096;
      cfg.img_width <= 13'd640;
      cfg.img_height <= 13'd640;
      cfg.score_threshold <= 16'd16384;
    end else if (cfg_write) begin
      case (cfg_index)
        aabd_pkg::REG_PAD_X: cfg.pad_x <= cfg_data;
        aabd_pkg::REG_PAD_Y: cfg.pad_y <= cfg_data;
        aabd_pkg::REG_SCALE_RATIO: cfg.scale_ratio <= cfg_data;
        aabd_pkg::REG_IMG_WIDTH: cfg.img_width <= cfg_data[aabd_pkg::LIMIT_W-1:0];
        aabd_pkg::REG_IMG_HEIGHT: cfg.img_height <= cfg_data[aabd_pkg::LIMIT_W-1:0];
        aabd_pkg::REG_SCORE_THRESHOLD: cfg.score_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  aabd_front #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_ANCHORS(MAX_ANCHORS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .kind(kind),
    .center_x(center_x),
    .center_y(center_y),
    .box_w(box_w),
    .box_h(box_h),
    .class_score(class_score),
    .last_score(last_score),
    .score_threshold(cfg.score_threshold),
    .job_push(job_push),
    .job(job_in)
  );

  aabd_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(aabd_pkg::JOB_DEPTH)
  ) u_job_q (
    .clk(clk),
    .rst(rst),
    .push(job_push),
    .wdata(job_in),
    .pop(job_pop),
    .rdata(job_out),
    .full(full),
    .empty(job_empty),
    .count(job_count)
  );

  aabd_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .job_empty(job_empty),
    .job(job_out),
    .job_pop(job_pop),
    .out_count(res_count),
    .res_push(res_push),
    .res(res_in)
  );

  aabd_fifo #(
    .WIDTH(RES_W),
    .DEPTH(aabd_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .wdata(res_in),
    .pop(pop),
    .rdata(res_out),
    .full(res_full),
    .empty(empty),
    .count(res_count)
  );

  assign anchor_index = res_out.anchor_index;
  assign label = res_out.label;
  assign score = res_out.score;
  assign left = res_out.left;
  assign top = res_out.top;
  assign right = res_out.right;
  assign bottom = res_out.bottom;

`ifndef SYNTH
  a_job_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (job_count != JCW'(aabd_pkg::JOB_DEPTH)))
    else $error("job queue written while full");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("back end took a job from an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");
`endif

endmodule

// File: dv/anchor_argmax_box_decode_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the anchor argmax and box decode core.
module anchor_argmax_box_decode_core_test;

  localparam int MAX_CLASSES = 1024;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int SATURATION_SCORES = 1030;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [aabd_pkg::COORD_W-1:0] center_x;
    logic [aabd_pkg::COORD_W-1:0] center_y;
    logic [aabd_pkg::COORD_W-1:0] box_w;
    logic [aabd_pkg::COORD_W-1:0] box_h;
    logic [aabd_pkg::SCORE_W-1:0] class_score;
    logic last_score;
  } anchor_item_t;

  typedef struct packed {
    anchor_item_t item;
    logic typed;
    aabd_pkg::result_t want;
  } directed_row_t;

  localparam int DIRECTED_SPLIT = 17;
  localparam int NUM_DIRECTED = 26;

  // Rows before the split run with the reset settings, the rest with extreme ones.
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd20000, 1'b1}, 1'b1,
      '{16'd0, 10'd0, 16'd20000, 17'd0, 17'd0, 17'd0, 17'd0}},
    '{'{aabd_pkg::KIND_FRAME, 16'd1234, 16'd4321, 16'd99, 16'd77, 16'd65535, 1'b1},
      1'b0, '0},
    '{'{aabd_pkg::KIND_BOX, 16'd160, 16'd320, 16'd64, 16'd32, 16'd65535, 1'b1},
      1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd100, 1'b0}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd30000, 1'b0}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd30000, 1'b0}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5, 1'b1}, 1'b1,
      '{16'd0, 10'd1, 16'd30000, 17'd128, 17'd304, 17'd192, 17'd336}},
    '{'{KIND_NONE, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1},
      1'b0, '0},
    '{'{aabd_pkg::KIND_BOX, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0, 1'b0},
      1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 1'b0}, 1'b0, '0},
    '{'{aabd_pkg::KIND_BOX, 16'd8000, 16'd8000, 16'd1000, 16'd1000, 16'd0, 1'b0},
      1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b1}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16385, 1'b1}, 1'b1,
      '{16'd3, 10'd0, 16'd16385, 17'd7500, 17'd7500, 17'd8500, 17'd8500}},
    '{'{aabd_pkg::KIND_BOX, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd0, 1'b0},
      1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 1'b1}, 1'b1,
      '{16'd4, 10'd0, 16'd65535, 17'd10240, 17'd10240, 17'd10240, 17'd10240}},
    '{'{aabd_pkg::KIND_BOX, 16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd0, 1'b0},
      1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b1}, 1'b1,
      '{16'd6, 10'd2, 16'd1, 17'd0, 17'd0, 17'd0, 17'd0}},
    '{'{aabd_pkg::KIND_BOX, 16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 1'b0},
      1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd40000, 1'b1}, 1'b1,
      '{16'd7, 10'd0, 16'd40000, 17'd0, 17'd0, 17'd0, 17'd0}},
    '{'{aabd_pkg::KIND_BOX, 16'd65535, 16'd100, 16'd2, 16'd65535, 16'd0, 1'b0},
      1'b0, '0},
    '{'{aabd_pkg::KIND_SCORE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd300, 1'b1}, 1'b1,
      '{16'd8, 10'd0, 16'd300, 17'd0, 17'd0, 17'd15, 17'd0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [aabd_pkg::REG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] kind = aabd_pkg::KIND_FRAME;
  logic [aabd_pkg::COORD_W-1:0] center_x = '0;
  logic [aabd_pkg::COORD_W-1:0] center_y = '0;
  logic [aabd_pkg::COORD_W-1:0] box_w = '0;
  logic [aabd_pkg::COORD_W-1:0] box_h = '0;
  logic [aabd_pkg::SCORE_W-1:0] class_score = '0;
  logic last_score = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [aabd_pkg::INDEX_W-1:0] anchor_index;
  logic [aabd_pkg::LABEL_W-1:0] label;
  logic [aabd_pkg::SCORE_W-1:0] score;
  logic [aabd_pkg::CORNER_W-1:0] left;
  logic [aabd_pkg::CORNER_W-1:0] top;
  logic [aabd_pkg::CORNER_W-1:0] right;
  logic [aabd_pkg::CORNER_W-1:0] bottom;

  // Travels with each item so that a typed-in expectation replaces the prediction.
  logic row_typed = 1'b0;
  aabd_pkg::result_t row_want = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int accepted_items = 0;
  int fail_count = 0;

  aabd_pkg::cfg_t pred_cfg;
  logic [aabd_pkg::INDEX_W-1:0] pred_anchor_count;
  logic [aabd_pkg::LABEL_W-1:0] pred_class_pos;
  logic [aabd_pkg::SCORE_W-1:0] pred_best_score;
  logic [aabd_pkg::LABEL_W-1:0] pred_best_label;
  logic [aabd_pkg::COORD_W-1:0] pred_cx, pred_cy, pred_w, pred_h;
  aabd_pkg::result_t pending_detections[$];

  anchor_argmax_box_decode_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .kind(kind), .center_x(center_x), .center_y(center_y),
    .box_w(box_w), .box_h(box_h), .class_score(class_score), .last_score(last_score),
    .empty(empty), .pop(pop),
    .anchor_index(anchor_index), .label(label), .score(score),
    .left(left), .top(top), .right(right), .bottom(bottom)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  task automatic queue_detection(input aabd_pkg::result_t d);
    pending_detections = {pending_detections, d};
  endtask

  // Floored product of the doubled offset and the ratio, clamped to the image.
  function automatic logic [aabd_pkg::CORNER_W-1:0] clamp_corner(input longint doubled,
      input logic [15:0] ratio, input logic [aabd_pkg::LIMIT_W-1:0] limit);
    longint prod;
    longint ceiling;
    prod = doubled * longint'(ratio);
    ceiling = longint'(limit) * 16;
    if (prod <= 0) return '0;
    prod = prod >>> aabd_pkg::FRAC_SHIFT;
    if (prod > ceiling) prod = ceiling;
    return prod[aabd_pkg::CORNER_W-1:0];
  endfunction

  task automatic predict_detection(input anchor_item_t it, input logic typed,
                                   input aabd_pkg::result_t want);
    aabd_pkg::result_t r;
    longint ax, ay;
    case (it.kind)
      aabd_pkg::KIND_FRAME: begin
        pred_anchor_count = '0;
        pred_class_pos = '0;
        pred_best_score = '0;
        pred_best_label = '0;
      end
      aabd_pkg::KIND_BOX: begin
        pred_cx = it.center_x;
        pred_cy = it.center_y;
        pred_w = it.box_w;
        pred_h = it.box_h;
        pred_class_pos = '0;
        pred_best_score = '0;
        pred_best_label = '0;
      end
      aabd_pkg::KIND_SCORE: begin
        if (it.class_score > pred_best_score) begin
          pred_best_score = it.class_score;
          pred_best_label = pred_class_pos;
        end
        if (pred_class_pos != aabd_pkg::LABEL_W'(MAX_CLASSES - 1)) pred_class_pos++;
        if (it.last_score) begin
          ax = longint'(pred_cx) - longint'(pred_cfg.pad_x);
          ay = longint'(pred_cy) - longint'(pred_cfg.pad_y);
          r.anchor_index = pred_anchor_count;
          r.label = pred_best_label;
          r.score = pred_best_score;
          r.left = clamp_corner(2 * ax - longint'(pred_w), pred_cfg.scale_ratio,
                                pred_cfg.img_width);
          r.top = clamp_corner(2 * ay - longint'(pred_h), pred_cfg.scale_ratio,
                               pred_cfg.img_height);
          r.right = clamp_corner(2 * ax + longint'(pred_w), pred_cfg.scale_ratio,
                                 pred_cfg.img_width);
          r.bottom = clamp_corner(2 * ay + longint'(pred_h), pred_cfg.scale_ratio,
                                  pred_cfg.img_height);
          if (typed) queue_detection(want);
          else if (pred_best_score > pred_cfg.score_threshold) queue_detection(r);
          pred_anchor_count++;
          pred_class_pos = '0;
          pred_best_score = '0;
          pred_best_label = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    aabd_pkg::result_t want;
    if (rst) begin
      pred_cfg.pad_x = '0;
      pred_cfg.pad_y = '0;
      pred_cfg.scale_ratio = 16'd4096;
      pred_cfg.img_width = 13'd640;
      pred_cfg.img_height = 13'd640;
      pred_cfg.score_threshold = 16'd16384;
      pred_anchor_count = '0;
      pred_class_pos = '0;
      pred_best_score = '0;
      pred_best_label = '0;
      pred_cx = '0;
      pred_cy = '0;
      pred_w = '0;
      pred_h = '0;
      pending_detections.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          aabd_pkg::REG_PAD_X: pred_cfg.pad_x = cfg_data;
          aabd_pkg::REG_PAD_Y: pred_cfg.pad_y = cfg_data;
          aabd_pkg::REG_SCALE_RATIO: pred_cfg.scale_ratio = cfg_data;
          aabd_pkg::REG_IMG_WIDTH: pred_cfg.img_width = cfg_data[aabd_pkg::LIMIT_W-1:0];
          aabd_pkg::REG_IMG_HEIGHT: pred_cfg.img_height = cfg_data[aabd_pkg::LIMIT_W-1:0];
          aabd_pkg::REG_SCORE_THRESHOLD: pred_cfg.score_threshold = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pending_detections.size() == 0) begin
          flag_error($sformatf("unexpected detection for anchor %0d", anchor_index));
        end else begin
          want = pending_detections.pop_front();
          compare_field("anchor_index", 32'(want.anchor_index), 32'(anchor_index));
          compare_field("label", 32'(want.label), 32'(label));
          compare_field("score", 32'(want.score), 32'(score));
          compare_field("left", 32'(want.left), 32'(left));
          compare_field("top", 32'(want.top), 32'(top));
          compare_field("right", 32'(want.right), 32'(right));
          compare_field("bottom", 32'(want.bottom), 32'(bottom));
        end
      end
      if (push && !full) begin
        predict_detection({kind, center_x, center_y, box_w, box_h, class_score, last_score},
                          row_typed, row_want);
      end
    end
  end

  task automatic send_item(input anchor_item_t it, input logic typed = 1'b0,
                           input aabd_pkg::result_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    kind <= it.kind;
    center_x <= it.center_x;
    center_y <= it.center_y;
    box_w <= it.box_w;
    box_h <= it.box_h;
    class_score <= it.class_score;
    last_score <= it.last_score;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (full);
    if (it.kind != KIND_NONE) accepted_items++;
  endtask

  // Holds the sender back until every detection has been taken and the pipe is quiet.
  task automatic settle_pipeline();
    push <= 1'b0;
    do @(posedge clk); while (pending_detections.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aabd_pkg::REG_INDEX_W-1:0] index,
                           input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_registers(input aabd_pkg::cfg_t c);
    write_reg(aabd_pkg::REG_PAD_X, c.pad_x);
    write_reg(aabd_pkg::REG_PAD_Y, c.pad_y);
    write_reg(aabd_pkg::REG_SCALE_RATIO, c.scale_ratio);
    write_reg(aabd_pkg::REG_IMG_WIDTH, {3'b0, c.img_width});
    write_reg(aabd_pkg::REG_IMG_HEIGHT, {3'b0, c.img_height});
    write_reg(aabd_pkg::REG_SCORE_THRESHOLD, c.score_threshold);
    cfg_write <= 1'b0;
  endtask

  function automatic anchor_item_t random_item();
    anchor_item_t it;
    it.kind = aabd_pkg::KIND_SCORE;
    it.center_x = 16'($urandom_range(0, 65535));
    it.center_y = 16'($urandom_range(0, 65535));
    it.box_w = 16'($urandom_range(0, 65535));
    it.box_h = 16'($urandom_range(0, 65535));
    it.class_score = 16'($urandom_range(0, 65535));
    it.last_score = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Mostly a box followed by its scores; some frame starts, stray kinds, orphan
  // scores, boxes cutting into a score run and runs missing their last flag.
  task automatic send_random_anchor();
    anchor_item_t it;
    int shape;
    int n_scores;
    logic drop_last;
    logic [aabd_pkg::SCORE_W-1:0] prev_score;
    shape = $urandom_range(99);
    it = random_item();
    prev_score = '0;
    if (shape < 4) begin
      it.kind = aabd_pkg::KIND_FRAME;
      send_item(it);
    end else if (shape < 7) begin
      it.kind = KIND_NONE;
      send_item(it);
    end else begin
      if (shape >= 12) begin
        it.kind = aabd_pkg::KIND_BOX;
        send_item(it);
      end
      n_scores = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      drop_last = ($urandom_range(19) == 0);
      for (int k = 0; k < n_scores; k++) begin
        if ($urandom_range(29) == 0) begin
          it = random_item();
          it.kind = aabd_pkg::KIND_BOX;
          send_item(it);
        end
        it = random_item();
        case ($urandom_range(9))
          0: it.class_score = '0;
          1: it.class_score = 16'hFFFF;
          2: it.class_score = prev_score;
          3: it.class_score = pred_cfg.score_threshold + 16'($urandom_range(0, 2)) - 16'd1;
          default: ;
        endcase
        it.last_score = (k == n_scores - 1) && !drop_last;
        prev_score = it.class_score;
        send_item(it);
      end
    end
  endtask

  initial begin
    aabd_pkg::cfg_t settings;
    anchor_item_t it;
    int target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 38;
    recv_idle_pct = 79;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (i == DIRECTED_SPLIT) begin
        settle_pipeline();
        settings.pad_x = 16'hFFFF;
        settings.pad_y = '0;
        settings.scale_ratio = 16'hFFFF;
        settings.img_width = 13'd8191;
        settings.img_height = '0;
        settings.score_threshold = '0;
        program_registers(settings);
      end
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    settle_pipeline();
    settings.pad_x = 16'($urandom_range(0, 2048));
    settings.pad_y = 16'($urandom_range(0, 2048));
    settings.scale_ratio = 16'($urandom_range(1024, 16384));
    settings.img_width = 13'($urandom_range(1, 8191));
    settings.img_height = 13'($urandom_range(1, 8191));
    settings.score_threshold = 16'($urandom_range(0, 40000));
    program_registers(settings);
    target = accepted_items + ITEMS_PER_PHASE;
    while (accepted_items < target) send_random_anchor();

    settle_pipeline();
    send_idle_pct = 79;
    recv_idle_pct = 38;
    settings.pad_x = '0;
    settings.pad_y = 16'hFFFF;
    settings.scale_ratio = 16'd1;
    settings.img_width = 13'd1;
    settings.img_height = 13'd8191;
    settings.score_threshold = 16'($urandom_range(0, 20000));
    program_registers(settings);
    target = accepted_items + ITEMS_PER_PHASE;
    while (accepted_items < target) send_random_anchor();

    settle_pipeline();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    settings.pad_x = 16'($urandom_range(0, 65535));
    settings.pad_y = 16'($urandom_range(0, 65535));
    settings.scale_ratio = 16'($urandom_range(0, 65535));
    settings.img_width = 13'($urandom_range(0, 8191));
    settings.img_height = 13'($urandom_range(0, 8191));
    settings.score_threshold = 16'($urandom_range(0, 30000));
    program_registers(settings);
    target = accepted_items + ITEMS_PER_PHASE;
    while (accepted_items < target) send_random_anchor();

    settle_pipeline();
    settings.pad_x = 16'($urandom_range(0, 4096));
    settings.pad_y = 16'($urandom_range(0, 4096));
    settings.scale_ratio = '0;
    settings.img_width = 13'd640;
    settings.img_height = 13'd480;
    settings.score_threshold = 16'd1000;
    program_registers(settings);

    // More scores than classes: the label sticks at the top class index.
    it = random_item();
    it.kind = aabd_pkg::KIND_BOX;
    send_item(it);
    for (int k = 0; k < SATURATION_SCORES; k++) begin
      it = random_item();
      it.class_score = (k == 1000) ? 16'd40000 : (k >= 1026) ? 16'd50000 : 16'd10;
      it.last_score = (k == SATURATION_SCORES - 1);
      send_item(it);
    end

    settle_pipeline();
    if (fail_count == 0 && pending_detections.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
